// ----- sv/hfc_pkg.sv -----
`default_nettype none
package hfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 3;
    localparam int TEMP_W   = 11;
    localparam int HUM_W    = 10;
    localparam int SCALED_W = 27;
    localparam int HPROD_W  = 26;

    localparam logic [BYTE_W-1:0]   CRC_INIT     = 8'hFF;
    localparam logic [BYTE_W-1:0]   CRC_POLY_RST = 8'h31;
    localparam logic [10:0]         TEMP_GAIN    = 11'd1750;
    localparam logic [9:0]          HUM_GAIN     = 10'd1000;
    localparam logic [SCALED_W-1:0] TEMP_OFFSET  = 27'd29490750;

    // Byte positions inside the six-byte frame.
    localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    // Register index carried in paddr[2].
    localparam logic REG_CRC_POLY = 1'b0;

    // Snapshot of the held words at the end of a frame.
    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic              temp_seen;
        logic [WORD_W-1:0] hum_word;
        logic              temp_ok;
        logic              hum_ok;
    } t_frame_res;

    // One byte through the CRC-8, MSB first.
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^27: estimate from x + x/65536, then one
    // correction step on the remainder.
    function automatic logic [11:0] div_full_scale(input logic [SCALED_W-1:0] x);
        logic [27:0] s;
        logic [11:0] q;
        logic [27:0] r;
        s = {1'b0, x} + 28'(x[26:16]);
        q = s[27:16];
        r = {1'b0, x} - ({q, 16'h0000} - 28'(q));
        if (r >= 28'd65535) begin
            q = q + 12'd1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- sv/humidity_frame_crc_and_convert_top.sv -----
// o_valid rises once the sixth byte of a frame has passed three register stages (frame
// snapshot, multiply, output); the other five bytes produce no result.
// Throughput: one byte transaction per cycle while o_stall is low.
// Reset (i_rst_n low at a rising edge) clears the frame position, CRC, held words and
// pipeline valids, and sets the CRC polynomial register back to 0x31.
`default_nettype none
module humidity_frame_crc_and_convert_top
    import hfc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Byte input channel.
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [BYTE_W-1:0]  i_frame_byte,
    input  wire logic               i_frame_start,
    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_temp_above,
    output logic [TEMP_W-1:0]       o_temp_tenths,
    output logic [HUM_W-1:0]        o_hum_tenths,
    output logic                    o_temp_ok,
    output logic                    o_hum_ok
);

    // The only register is the CRC polynomial. The port never waits, and
    // addresses beyond the register list read as zero and ignore writes.
    logic [BYTE_W-1:0] r_crc_poly;
    logic              cfg_wr;
    logic              res_valid;
    logic              res_stall;
    t_frame_res        res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CRC_POLY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= CRC_POLY_RST;
        end else if (cfg_wr) begin
            r_crc_poly <= pwdata[BYTE_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_CRC_POLY) begin
            prdata = {24'h000000, r_crc_poly};
        end else begin
            prdata = '0;
        end
    end

    // Byte tracking: position in the frame, running CRC, and the held
    // temperature and humidity words. At the sixth byte a snapshot of the
    // held words and both check flags is registered for conversion.
    hfc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_crc_poly    (r_crc_poly),
        .i_valid       (i_valid),
        .i_frame_byte  (i_frame_byte),
        .i_frame_start (i_frame_start),
        .o_stall       (o_stall),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_stall   (res_stall)
    );

    // Conversion: one stage multiplies each word by its gain, the next takes
    // the distance from the 45 degree point and divides by full scale with a
    // reciprocal estimate and a single correction. A temperature that was
    // never checked good reads as zero.
    hfc_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_res_stall   (res_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_temp_above  (o_temp_above),
        .o_temp_tenths (o_temp_tenths),
        .o_hum_tenths  (o_hum_tenths),
        .o_temp_ok     (o_temp_ok),
        .o_hum_ok      (o_hum_ok)
    );

endmodule
`default_nettype wire

// ----- sv/hfc_frame.sv -----
`default_nettype none
module hfc_frame
    import hfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [BYTE_W-1:0] i_crc_poly,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_frame_byte,
    input  wire logic              i_frame_start,
    output logic                   o_stall,
    output logic                   o_res_valid,
    output t_frame_res             o_res,
    input  wire logic              i_res_stall
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [WORD_W-1:0] r_wbuf, n_wbuf;
    logic [WORD_W-1:0] r_temp_word, n_temp_word;
    logic              r_temp_seen, n_temp_seen;
    logic              r_temp_good, n_temp_good;
    logic [WORD_W-1:0] r_hum_word, n_hum_word;
    logic              r_res_valid;
    t_frame_res        r_res, n_res;
    logic              n_emit;
    logic              load_en;
    logic              accept;
    logic [POS_W-1:0]  pos;
    logic              crc_match;

    assign load_en = !r_res_valid || !i_res_stall;
    assign o_stall = !load_en;
    assign accept  = i_valid && load_en;

    always_comb begin
        pos = (i_frame_start || (r_pos > POS_H_CRC)) ? POS_T_HI : r_pos;
        crc_match   = (r_crc == i_frame_byte);
        n_crc       = r_crc;
        n_wbuf      = r_wbuf;
        n_temp_word = r_temp_word;
        n_temp_seen = r_temp_seen;
        n_temp_good = r_temp_good;
        n_hum_word  = r_hum_word;
        n_emit      = 1'b0;
        case (pos)
            POS_T_HI, POS_H_HI: begin
                n_crc  = crc8_byte(CRC_INIT, i_frame_byte, i_crc_poly);
                n_wbuf = {i_frame_byte, 8'h00};
            end
            POS_T_LO, POS_H_LO: begin
                n_crc  = crc8_byte(r_crc, i_frame_byte, i_crc_poly);
                n_wbuf = {r_wbuf[WORD_W-1:BYTE_W], i_frame_byte};
            end
            POS_T_CRC: begin
                n_temp_good = crc_match;
                if (crc_match) begin
                    n_temp_word = r_wbuf;
                    n_temp_seen = 1'b1;
                end
                n_crc = CRC_INIT;
            end
            default: begin
                if (crc_match) begin
                    n_hum_word = r_wbuf;
                end
                n_crc  = CRC_INIT;
                n_emit = 1'b1;
            end
        endcase
        n_pos = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;

        n_res.temp_word = r_temp_word;
        n_res.temp_seen = r_temp_seen;
        n_res.hum_word  = n_hum_word;
        n_res.temp_ok   = r_temp_good;
        n_res.hum_ok    = crc_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_INIT;
            r_wbuf      <= '0;
            r_temp_word <= '0;
            r_temp_seen <= 1'b0;
            r_temp_good <= 1'b0;
            r_hum_word  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos       <= n_pos;
                r_crc       <= n_crc;
                r_wbuf      <= n_wbuf;
                r_temp_word <= n_temp_word;
                r_temp_seen <= n_temp_seen;
                r_temp_good <= n_temp_good;
                r_hum_word  <= n_hum_word;
            end
            if (load_en) begin
                r_res_valid <= accept && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ----- sv/hfc_convert.sv -----
`default_nettype none
module hfc_convert
    import hfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire t_frame_res        i_res,
    output logic                   o_res_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_temp_above,
    output logic [TEMP_W-1:0]      o_temp_tenths,
    output logic [HUM_W-1:0]       o_hum_tenths,
    output logic                   o_temp_ok,
    output logic                   o_hum_ok
);

    // Multiply stage.
    logic                r_b_valid;
    logic [SCALED_W-1:0] r_scaled;
    logic [HPROD_W-1:0]  r_hprod;
    logic                r_b_seen;
    logic                r_b_tok;
    logic                r_b_hok;

    // Output stage.
    logic                r_c_valid;
    logic                r_above, n_above;
    logic [TEMP_W-1:0]   r_temp, n_temp;
    logic [HUM_W-1:0]    r_hum, n_hum;
    logic                r_tok;
    logic                r_hok;

    logic                c_en;
    logic                b_en;
    logic [SCALED_W-1:0] temp_dist;
    logic [11:0]         temp_q;
    logic [11:0]         hum_q;

    assign c_en        = !r_c_valid || !i_stall;
    assign b_en        = !r_b_valid || c_en;
    assign o_res_stall = !b_en;

    always_comb begin
        if (r_scaled >= TEMP_OFFSET) begin
            temp_dist = r_scaled - TEMP_OFFSET;
        end else begin
            temp_dist = TEMP_OFFSET - r_scaled;
        end
        temp_q = div_full_scale(temp_dist);
        hum_q  = div_full_scale(SCALED_W'(r_hprod));
        if (r_b_seen) begin
            n_above = (r_scaled >= TEMP_OFFSET);
            n_temp  = temp_q[TEMP_W-1:0];
        end else begin
            n_above = 1'b0;
            n_temp  = '0;
        end
        n_hum = hum_q[HUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (b_en) begin
                r_b_valid <= i_res_valid;
            end
            if (c_en) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_scaled <= SCALED_W'(i_res.temp_word) * SCALED_W'(TEMP_GAIN);
            r_hprod  <= HPROD_W'(i_res.hum_word) * HPROD_W'(HUM_GAIN);
            r_b_seen <= i_res.temp_seen;
            r_b_tok  <= i_res.temp_ok;
            r_b_hok  <= i_res.hum_ok;
        end
        if (c_en) begin
            r_above <= n_above;
            r_temp  <= n_temp;
            r_hum   <= n_hum;
            r_tok   <= r_b_tok;
            r_hok   <= r_b_hok;
        end
    end

    assign o_valid       = r_c_valid;
    assign o_temp_above  = r_above;
    assign o_temp_tenths = r_temp;
    assign o_hum_tenths  = r_hum;
    assign o_temp_ok     = r_tok;
    assign o_hum_ok      = r_hok;

endmodule
`default_nettype wire

// ----- verif/tb_humidity_frame_crc_and_convert_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_humidity_frame_crc_and_convert_top;
    import hfc_pkg::*;

    // A result leaves the block through its register stages after the sixth byte of a frame.
    // The drain pause is longer than that path.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any accepted transaction on either channel before the run
    // is declared hung. The slowest legal stretch (sender gap plus a heavy stall
    // run plus a register access) is far below this.
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // The polynomial register is register 0 of the configuration space.
    localparam logic [2:0]  POLY_ADDR    = {REG_CRC_POLY, 2'b00};
    // 1750 * v at exactly 45 degrees, and the full-scale divisor.
    localparam logic [31:0] OFFSET_AT_45 = 32'd29490750;
    localparam logic [31:0] FULL_SCALE   = 32'd65535;

    typedef struct packed {
        logic              above;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic              temp_ok;
        logic              hum_ok;
    } t_meas;

    // One byte transaction as queued for the sender. A directed row may carry
    // a result typed in by hand; it then replaces the predicted one.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              typed;
        t_meas             res;
    } t_byte_item;

    typedef enum logic [0:0] {CRC_GOOD, CRC_BAD} t_crc_mode;

    // One row of the directed table is a word: high byte, low byte, CRC byte.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] word;
        t_crc_mode         crc;
        logic              typed;
        t_meas             res;
    } t_word_row;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    // Directed part. Two rows make one frame unless a start cuts a frame off.
    //   Rows 0-1: both CRCs bad before any good word, so the held values are zero.
    //   Rows 2-3: no frame start, the position wraps; word extremes with good CRCs.
    //   Row 4:    a temperature word alone, then cut off by a new frame start.
    //   Rows 5-6: both CRCs bad; the cut-off frame's temperature stays held.
    //   Rows 7-8: temperature just above 45 degrees, humidity at mid scale.
    localparam t_word_row DIRECTED [0:8] = '{
        '{1'b1, 16'h1234, CRC_BAD,  1'b0, '0},
        '{1'b0, 16'h5678, CRC_BAD,  1'b1, '{1'b0, 11'd0, 10'd0, 1'b0, 1'b0}},
        '{1'b0, 16'h0000, CRC_GOOD, 1'b0, '0},
        '{1'b0, 16'hFFFF, CRC_GOOD, 1'b1, '{1'b0, 11'd450, 10'd1000, 1'b1, 1'b1}},
        '{1'b1, 16'hFFFF, CRC_GOOD, 1'b0, '0},
        '{1'b1, 16'h41A7, CRC_BAD,  1'b0, '0},
        '{1'b0, 16'h0000, CRC_BAD,  1'b1, '{1'b1, 11'd1300, 10'd1000, 1'b0, 1'b0}},
        '{1'b1, 16'd16852, CRC_GOOD, 1'b0, '0},
        '{1'b0, 16'h8000, CRC_GOOD, 1'b0, '0}
    };

    // Every input of the block starts at a known value.
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [2:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_frame_byte  = '0;
    logic              i_frame_start = 1'b0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic              o_temp_above;
    logic [TEMP_W-1:0] o_temp_tenths;
    logic [HUM_W-1:0]  o_hum_tenths;
    logic              o_temp_ok;
    logic              o_hum_ok;

    humidity_frame_crc_and_convert_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_byte  (i_frame_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_temp_above  (o_temp_above),
        .o_temp_tenths (o_temp_tenths),
        .o_hum_tenths  (o_hum_tenths),
        .o_temp_ok     (o_temp_ok),
        .o_hum_ok      (o_hum_ok)
    );

    // Stimulus waiting to be sent, and measurements expected from the block.
    t_byte_item byte_q[$];
    t_meas      meas_q[$];
    t_byte_item cur_item = '0;
    bit         in_taken = 1'b0;
    int         fail_count = 0;
    int         quiet_cycles = 0;

    // Shadow of the frame decoder, mirroring the block's state after reset.
    logic [BYTE_W-1:0] m_poly      = CRC_POLY_RST;
    logic [POS_W-1:0]  m_pos       = POS_T_HI;
    logic [BYTE_W-1:0] m_crc       = CRC_INIT;
    logic [WORD_W-1:0] m_word      = '0;
    logic              m_temp_good = 1'b0;
    logic              m_above     = 1'b0;
    logic [TEMP_W-1:0] m_temp      = '0;
    logic [HUM_W-1:0]  m_hum       = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // CRC-8, MSB first, over one byte.
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] d,
                                                    input logic [BYTE_W-1:0] poly);
        logic [BYTE_W-1:0] c;
        c = crc ^ d;
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ poly) : {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] word_crc(input logic [WORD_W-1:0] w,
                                                   input logic [BYTE_W-1:0] poly);
        return crc8_step(crc8_step(CRC_INIT, w[15:8], poly), w[7:0], poly);
    endfunction

    // Advances the shadow decoder by one byte. The sixth byte of a frame
    // yields the measurement that the block is to report.
    task automatic decode_frame_byte(input logic [BYTE_W-1:0] d, input logic start,
                                     output bit got, output t_meas res);
        logic [POS_W-1:0] pos;
        logic [31:0]      scaled;
        logic [31:0]      offset_dist;
        logic             hum_good;
        got = 1'b0;
        res = '0;
        pos = m_pos;
        // A frame start, or a position outside the frame, restarts at byte 0.
        if (start || pos > POS_H_CRC) begin
            pos = POS_T_HI;
        end
        case (pos)
            POS_T_HI, POS_H_HI: begin
                m_crc  = crc8_step(CRC_INIT, d, m_poly);
                m_word = {d, 8'h00};
            end
            POS_T_LO, POS_H_LO: begin
                m_crc       = crc8_step(m_crc, d, m_poly);
                m_word[7:0] = d;
            end
            POS_T_CRC: begin
                if (m_crc == d) begin
                    m_temp_good = 1'b1;
                    scaled = 32'd1750 * 32'(m_word);
                    if (scaled >= OFFSET_AT_45) begin
                        m_above     = 1'b1;
                        offset_dist = scaled - OFFSET_AT_45;
                    end else begin
                        m_above     = 1'b0;
                        offset_dist = OFFSET_AT_45 - scaled;
                    end
                    m_temp = TEMP_W'(offset_dist / FULL_SCALE);
                end else begin
                    m_temp_good = 1'b0;
                end
                m_crc = CRC_INIT;
            end
            default: begin
                hum_good = (m_crc == d);
                if (hum_good) begin
                    m_hum = HUM_W'((32'd1000 * 32'(m_word)) / FULL_SCALE);
                end
                m_crc = CRC_INIT;
                res   = '{m_above, m_temp, m_hum, m_temp_good, hum_good};
                got   = 1'b1;
            end
        endcase
        m_pos = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] d, input logic start);
        byte_q.push_back('{d, start, 1'b0, '0});
    endtask

    // Queues one word and its CRC byte. A bad CRC flips one bit of the good one.
    task automatic push_word(input logic start, input logic [WORD_W-1:0] w,
                             input t_crc_mode mode, input logic typed, input t_meas res);
        logic [BYTE_W-1:0] crc;
        crc = word_crc(w, m_poly);
        if (mode == CRC_BAD) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        end
        push_byte(w[15:8], start);
        push_byte(w[7:0], 1'b0);
        byte_q.push_back('{crc, 1'b0, typed, res});
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd16851 + WORD_W'($urandom_range(0, 1));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic t_crc_mode pick_crc();
        return ($urandom_range(0, 4) == 0) ? CRC_BAD : CRC_GOOD;
    endfunction

    // Mostly well-formed frames with random words, mixed with frames cut off
    // by a new start and loose bytes that may carry a start anywhere.
    task automatic queue_traffic(input int n_bytes);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                push_word($urandom_range(0, 4) != 0, pick_word(), pick_crc(), 1'b0, '0);
                push_word(1'b0, pick_word(), pick_crc(), 1'b0, '0);
                sent += 6;
            end else if (kind == 8) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    push_byte(BYTE_W'($urandom), i == 0);
                end
                sent += len;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    push_byte(BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                end
                sent += len;
            end
        end
    endtask

    // Two-phase register access; the transfer completes at the edge with pready high.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= POLY_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_crc_poly(input logic [BYTE_W-1:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd[BYTE_W-1:0] !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("crc_poly read back: expected %02h, got %02h", want, rd[7:0]);
            end
        end
    endtask

    task automatic set_crc_poly(input logic [BYTE_W-1:0] poly);
        logic [31:0] rd;
        apb_access(1'b1, {24'h0, poly}, rd);
        m_poly = poly;
        check_crc_poly(poly);
    endtask

    // Waits until every byte is sent and every measurement has come back,
    // then lets the result pipeline run empty.
    task automatic wait_idle();
        while (byte_q.size() != 0 || i_valid || meas_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps. A payload
    // stays put until the block has taken it.
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left != 0 || byte_q.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end
            end else begin
                cur_item = byte_q.pop_front();
                i_valid       <= 1'b1;
                i_frame_byte  <= cur_item.data;
                i_frame_start <= cur_item.start;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: windows with no stall, light stalls and heavy stalls.
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            default:  i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Monitor: every accepted byte goes through the shadow decoder, and every
    // accepted measurement is compared against the oldest one expected.
    always @(posedge i_clk) begin : monitor
        bit    got;
        bit    active;
        t_meas pred;
        t_meas want;
        active = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            in_taken = 1'b1;
            active   = 1'b1;
            decode_frame_byte(i_frame_byte, i_frame_start, got, pred);
            if (cur_item.typed) begin
                meas_q.push_back(cur_item.res);
            end else if (got) begin
                meas_q.push_back(pred);
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            active = 1'b1;
            if (meas_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected measurement: above=%0d temp=%0d hum=%0d ok=%0d/%0d",
                             o_temp_above, o_temp_tenths, o_hum_tenths, o_temp_ok, o_hum_ok);
                end
            end else begin
                want = meas_q.pop_front();
                if (o_temp_above !== want.above || o_temp_tenths !== want.temp ||
                    o_hum_tenths !== want.hum || o_temp_ok !== want.temp_ok ||
                    o_hum_ok !== want.hum_ok) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("measurement mismatch: expected above=%0d temp=%0d %s",
                                 want.above, want.temp, "");
                        $display("    hum=%0d ok=%0d/%0d, got above=%0d temp=%0d",
                                 want.hum, want.temp_ok, want.hum_ok,
                                 o_temp_above, o_temp_tenths);
                        $display("    hum=%0d ok=%0d/%0d",
                                 o_hum_tenths, o_temp_ok, o_hum_ok);
                    end
                end
            end
        end
        quiet_cycles = active ? 0 : quiet_cycles + 1;
    end

    // A run in which nothing moves for too long is hung.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        // Reset is held from the start of the run and released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The polynomial register must come out of reset at the sensor default.
        check_crc_poly(CRC_POLY_RST);

        // Directed table, then random traffic, run with the reset polynomial.
        for (int r = 0; r < $size(DIRECTED); r++) begin
            push_word(DIRECTED[r].start, DIRECTED[r].word, DIRECTED[r].crc,
                      DIRECTED[r].typed, DIRECTED[r].res);
        end
        queue_traffic(400);
        wait_idle();

        // Random traffic under several polynomials, both extremes included.
        // The register is only touched while the block has nothing in flight.
        set_crc_poly(8'h00);
        queue_traffic(300);
        wait_idle();

        set_crc_poly(8'hFF);
        queue_traffic(300);
        wait_idle();

        set_crc_poly(BYTE_W'($urandom));
        queue_traffic(300);
        wait_idle();

        set_crc_poly(CRC_POLY_RST);
        queue_traffic(300);
        wait_idle();

        if (fail_count == 0 && meas_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
